// ----- rtl/core/ipdbx_pkg.sv -----
// Package: shared constants, character helpers and the result record of the body extractor.
`default_nettype none
package ipdbx_pkg;

  localparam int unsigned LenBitsDefault = 16;

  localparam int unsigned MarkerLen = 5;
  localparam logic [2:0]  MarkerLast = 3'(MarkerLen - 1);

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // separator progress codes; SepFound means the body has started
  localparam logic [2:0] SepNone  = 3'd0;
  localparam logic [2:0] SepCr    = 3'd1;
  localparam logic [2:0] SepCrLf  = 3'd2;
  localparam logic [2:0] SepCrLfCr = 3'd3;
  localparam logic [2:0] SepFound = 3'd4;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       has_data;
    logic       body_last;
  } res_t;

  // characters of "+IPD,"
  function automatic logic [7:0] marker_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h2B;
      3'd1:    ch = 8'h49;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h2C;
      default: ch = 8'h2B;
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ipd_deframer_http_body_extractor.sv -----
// Top level: modem response deframer that passes only the HTTP body bytes.
// One byte is taken per transfer and, once the pipe is primed, one byte can be
// taken every cycle while no result is due into a full output buffer. A byte
// first lands in an input register; from there a single pass through the
// frame tracker (the "+IPD," matcher, the atol-style length reader, the
// payload counter and the CR LF CR LF search) updates the tracker state and
// decides whether a result is due. A result goes out for a body byte, and
// always for the byte flagged end_of_response (body_last high, has_data
// telling whether that byte is body too); that byte also returns all tracker
// state to reset. Results wait in an output register backed by one skid
// entry, so the input keeps moving while a result waits to be taken. Bytes
// that yield no result move on even when the output side is stalled. The
// parsed length saturates at 2^LEN_BITS-1; a zero or negative length passes
// all remaining bytes as payload.
`default_nettype none
module ipd_deframer_http_body_extractor #(
  parameter int unsigned LEN_BITS = ipdbx_pkg::LenBitsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       end_of_response_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      body_byte_o,
  output logic            has_data_o,
  output logic            body_last_o
);
  import ipdbx_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_fire;
  logic       emit;
  logic       res_ready;
  res_t       res;
  res_t       out_res;

  // advance the input register unless a result is due and the buffer is full
  assign s1_fire    = s1_valid_q && (res_ready || !emit);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
      s1_last_q <= end_of_response_i;
    end
  end

  ipdbx_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .fire_i  (s1_fire),
    .result_o(res),
    .emit_o  (emit)
  );

  ipdbx_skid u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_fire && emit),
    .data_i (res),
    .ready_o(res_ready),
    .valid_o(out_valid_o),
    .data_o (out_res),
    .ready_i(out_ready_i)
  );

  assign body_byte_o = out_res.body_byte;
  assign has_data_o  = out_res.has_data;
  assign body_last_o = out_res.body_last;

  // a result handed to the buffer must always find room
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |-> res_ready)
    else $error("result transfer into a full output buffer");

  // a result without body data carries a zero byte
  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> (body_byte_o == 8'h00))
    else $error("body byte not zero without data");

  // a result without data can only come from the end-of-response byte
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_data_o) |-> body_last_o)
    else $error("empty result that is not the last one");

  // input stalls only while the input register holds a byte
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

endmodule
`default_nettype wire

// ----- rtl/core/ipdbx_parser.sv -----
// Frame tracker: marker match, length parse, payload count and body separator search.
`default_nettype none
module ipdbx_parser #(
  parameter int unsigned LEN_BITS = ipdbx_pkg::LenBitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_i,
  input  wire logic             last_i,
  input  wire logic             fire_i,
  output ipdbx_pkg::res_t       result_o,
  output logic                  emit_o
);
  import ipdbx_pkg::*;

  typedef enum logic [1:0] {
    PhSearch  = 2'd0,
    PhLength  = 2'd1,
    PhCounted = 2'd2,
    PhToEnd   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    StgWs     = 2'd0,
    StgDigits = 2'd1,
    StgDone   = 2'd2
  } stage_e;

  localparam int unsigned WideW = LEN_BITS + 4;
  localparam logic [LEN_BITS-1:0] LenMax = '1;

  phase_e              phase_q, phase_d;
  stage_e              stage_q, stage_d;
  logic [2:0]          marker_q, marker_d;
  logic                neg_q, neg_d;
  logic [LEN_BITS-1:0] len_q, len_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;
  logic [2:0]          sep_q, sep_d;

  logic [WideW-1:0]    len_wide;
  logic [LEN_BITS-1:0] len_acc;
  logic [LEN_BITS-1:0] rem_dec;
  logic [2:0]          sep_step;
  logic                body;

  // length * 10 + digit, saturated
  assign len_wide = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0}
                  + {{(WideW-4){1'b0}}, byte_i[3:0]};
  assign len_acc  = (|len_wide[WideW-1:LEN_BITS]) ? LenMax : len_wide[LEN_BITS-1:0];
  assign rem_dec  = rem_q - 1'b1;

  always_comb begin
    case (sep_q)
      SepNone:   sep_step = (byte_i == ChCr) ? SepCr : SepNone;
      SepCr:     sep_step = (byte_i == ChLf) ? SepCrLf : (byte_i == ChCr) ? SepCr : SepNone;
      SepCrLf:   sep_step = (byte_i == ChCr) ? SepCrLfCr : SepNone;
      SepCrLfCr: sep_step = (byte_i == ChLf) ? SepFound : (byte_i == ChCr) ? SepCr : SepNone;
      default:   sep_step = SepFound;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    stage_d  = stage_q;
    marker_d = marker_q;
    neg_d    = neg_q;
    len_d    = len_q;
    rem_d    = rem_q;
    sep_d    = sep_q;
    body     = 1'b0;

    case (phase_q)
      PhSearch: begin
        if (byte_i == marker_char(marker_q)) begin
          if (marker_q == MarkerLast) begin
            marker_d = '0;
            phase_d  = PhLength;
            stage_d  = StgWs;
            neg_d    = 1'b0;
            len_d    = '0;
          end else begin
            marker_d = marker_q + 3'd1;
          end
        end else begin
          marker_d = (byte_i == ChPlus) ? 3'd1 : 3'd0;
        end
      end
      PhLength: begin
        if (byte_i == ChColon) begin
          if (neg_q || (len_q == '0)) begin
            phase_d = PhToEnd;
          end else begin
            rem_d   = len_q;
            phase_d = PhCounted;
          end
        end else if (stage_q == StgWs) begin
          if (is_space(byte_i)) begin
            stage_d = StgWs;
          end else if (byte_i == ChPlus) begin
            stage_d = StgDigits;
          end else if (byte_i == ChMinus) begin
            neg_d   = 1'b1;
            stage_d = StgDigits;
          end else if (is_digit(byte_i)) begin
            len_d   = len_acc;
            stage_d = StgDigits;
          end else begin
            stage_d = StgDone;
          end
        end else if (stage_q == StgDigits) begin
          if (is_digit(byte_i)) begin
            len_d = len_acc;
          end else begin
            stage_d = StgDone;
          end
        end
      end
      PhCounted: begin
        body  = (sep_q == SepFound);
        sep_d = sep_step;
        rem_d = rem_dec;
        if (rem_dec == '0) begin
          phase_d  = PhSearch;
          marker_d = '0;
        end
      end
      default: begin
        body  = (sep_q == SepFound);
        sep_d = sep_step;
      end
    endcase
  end

  assign emit_o             = body || last_i;
  assign result_o.body_byte = body ? byte_i : 8'h00;
  assign result_o.has_data  = body;
  assign result_o.body_last = last_i;

  // an end-of-response byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSearch;
      stage_q  <= StgWs;
      marker_q <= '0;
      neg_q    <= 1'b0;
      len_q    <= '0;
      rem_q    <= '0;
      sep_q    <= SepNone;
    end else if (fire_i) begin
      if (last_i) begin
        phase_q  <= PhSearch;
        stage_q  <= StgWs;
        marker_q <= '0;
        neg_q    <= 1'b0;
        len_q    <= '0;
        rem_q    <= '0;
        sep_q    <= SepNone;
      end else begin
        phase_q  <= phase_d;
        stage_q  <= stage_d;
        marker_q <= marker_d;
        neg_q    <= neg_d;
        len_q    <= len_d;
        rem_q    <= rem_d;
        sep_q    <= sep_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ipdbx_skid.sv -----
// Result register with a skid stage, so the upstream ready is a registered signal.
`default_nettype none
module ipdbx_skid (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire ipdbx_pkg::res_t data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output ipdbx_pkg::res_t      data_o,
  input  wire logic            ready_i
);
  import ipdbx_pkg::*;

  logic main_valid_q;
  logic skid_valid_q;
  res_t main_q;
  res_t skid_q;
  logic pop;
  logic push;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign pop     = main_valid_q && ready_i;
  assign push    = valid_i && !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (!main_valid_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for the IPD deframer: random modem responses against a byte-level body predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipdbx_pkg::*;

  localparam int unsigned LenBits = 16;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};
  localparam int NumItems = 1900;

  // "+IPD," with the first character at index 0
  localparam logic [4:0][7:0] MarkText = {8'h2C, 8'h44, 8'h50, 8'h49, 8'h2B};
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  typedef enum logic [1:0] {PhHunt, PhLen, PhCount, PhDrain} frame_phase_e;
  typedef enum logic [1:0] {StgBlank, StgDigits, StgDone} len_stage_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       eor;
  } rx_item_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       end_of_response_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] body_byte_o;
  logic       has_data_o;
  logic       body_last_o;

  ipd_deframer_http_body_extractor #(
    .LEN_BITS(LenBits)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .end_of_response_i(end_of_response_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .body_byte_o      (body_byte_o),
    .has_data_o       (has_data_o),
    .body_last_o      (body_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run; the slowest legal run needs well under a tenth of this.
  initial begin
    #(4_000_000);
    $display("[ipd_deframer_http_body_extractor] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Body predictor: its own copy of the frame tracker state
  // ---------------------------------------------------------------------------
  frame_phase_e       frame_phase;
  logic [2:0]         mark_cnt;
  len_stage_e         len_stage;
  logic               len_neg;
  logic [LenBits-1:0] len_val;
  logic [LenBits-1:0] pay_left;
  logic [2:0]         sep_state;

  res_t     body_expect[$];
  rx_item_t rx_pending[$];

  int bytes_sent;
  int responses_seen;
  int body_bytes;
  int results_seen;
  int stall_cycles;
  int mismatches;

  task automatic reset_tracker();
    frame_phase = PhHunt;
    mark_cnt    = 3'd0;
    len_stage   = StgBlank;
    len_neg     = 1'b0;
    len_val     = '0;
    pay_left    = '0;
    sep_state   = SepNone;
  endtask

  // Advance the CR LF CR LF search; report whether the byte is already body.
  function automatic logic advance_separator(input logic [7:0] c);
    if (sep_state == SepFound) return 1'b1;
    case (sep_state)
      SepNone:   sep_state = (c == ChCr) ? SepCr : SepNone;
      SepCr:     sep_state = (c == ChLf) ? SepCrLf : (c == ChCr) ? SepCr : SepNone;
      SepCrLf:   sep_state = (c == ChCr) ? SepCrLfCr : SepNone;
      default:   sep_state = (c == ChLf) ? SepFound : (c == ChCr) ? SepCr : SepNone;
    endcase
    return 1'b0;
  endfunction

  // Append one decimal digit to the length, saturating at the counter's top.
  function automatic logic [LenBits-1:0] len_after_digit(input logic [7:0] c);
    logic [LenBits+4:0] grown;
    grown = (LenBits+5)'(len_val * 10 + (c - ChZero));
    return (grown > LenMax) ? LenMax : grown[LenBits-1:0];
  endfunction

  // Run one accepted byte through the tracker and queue the result it causes.
  task automatic deframe_byte(input logic [7:0] c, input logic last);
    logic body;
    body = 1'b0;
    case (frame_phase)
      PhHunt: begin
        if (c == MarkText[mark_cnt]) mark_cnt = mark_cnt + 3'd1;
        else mark_cnt = (c == ChPlus) ? 3'd1 : 3'd0;
        if (mark_cnt == MarkerLen) begin
          mark_cnt    = 3'd0;
          frame_phase = PhLen;
          len_stage   = StgBlank;
          len_neg     = 1'b0;
          len_val     = '0;
        end
      end
      PhLen: begin
        if (c == ChColon) begin
          if (len_neg || len_val == '0) begin
            frame_phase = PhDrain;
          end else begin
            pay_left    = len_val;
            frame_phase = PhCount;
          end
        end else if (len_stage == StgBlank) begin
          if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
            len_stage = StgBlank;
          end else if (c == ChPlus) begin
            len_stage = StgDigits;
          end else if (c == ChMinus) begin
            len_neg   = 1'b1;
            len_stage = StgDigits;
          end else if (c >= ChZero && c <= ChNine) begin
            len_val   = len_after_digit(c);
            len_stage = StgDigits;
          end else begin
            len_stage = StgDone;
          end
        end else if (len_stage == StgDigits) begin
          if (c >= ChZero && c <= ChNine) len_val = len_after_digit(c);
          else len_stage = StgDone;
        end
      end
      PhCount: begin
        body     = advance_separator(c);
        pay_left = pay_left - 1'b1;
        if (pay_left == '0) begin
          frame_phase = PhHunt;
          mark_cnt    = 3'd0;
        end
      end
      default: body = advance_separator(c);
    endcase
    if (body) body_bytes++;
    if (last) begin
      // the end byte always reports, body or not, and clears the tracker
      body_expect.push_back('{body_byte: body ? c : 8'h00, has_data: body, body_last: 1'b1});
      responses_seen++;
      reset_tracker();
    end else if (body) begin
      body_expect.push_back('{body_byte: c, has_data: 1'b1, body_last: 1'b0});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic eor);
    rx_pending.push_back('{rx_byte: b, eor: eor});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  task automatic push_blank_line();
    push_byte(ChCr, 1'b0);
    push_byte(ChLf, 1'b0);
    push_byte(ChCr, 1'b0);
    push_byte(ChLf, 1'b0);
  endtask

  // Flag the last queued byte as the end of the response.
  task automatic mark_end();
    rx_item_t tail;
    tail = rx_pending.pop_back();
    tail.eor = 1'b1;
    rx_pending.push_back(tail);
  endtask

  // Length text that parses to n, dressed in the ways atol tolerates.
  function automatic string length_text(input int n);
    string s;
    s = $sformatf("%0d", n);
    case ($urandom_range(0, 9))
      0: s = {" \t", s};
      1: s = {"+", s};
      2: s = {s, "x7"};
      3: s = {"00", s};
      4: s = {"\v -", s, "- "};
      default: ;
    endcase
    if (s[0] == "\v") s = $sformatf("%0d", n);
    return s;
  endfunction

  // Length text that opens a frame running to the end of the response.
  function automatic string open_length_text();
    case ($urandom_range(0, 8))
      0: return "";
      1: return "0";
      2: return "-";
      3: return $sformatf("-%0d", $urandom_range(1, 500));
      4: return "-999999999";
      5: return "abc";
      6: return " \t+0";
      7: return "123456789";
      default: return "  -07x";
    endcase
  endfunction

  // One response: an HTTP head, most often the blank line, and a body, cut
  // into "+IPD," frames with random junk between them.
  task automatic push_response();
    logic [7:0] stream[$];
    int take;
    int claimed;
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) stream.push_back($urandom_range(0, 1) ? ChCr : ChLf);
      else stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if ($urandom_range(0, 9) != 0) begin
      stream.push_back(ChCr);
      stream.push_back(ChLf);
      stream.push_back(ChCr);
      stream.push_back(ChLf);
    end
    repeat ($urandom_range(0, 24)) stream.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 2) == 0 ? ChPlus :
                                            8'($urandom_range(0, 255)), 1'b0);
    while (stream.size() != 0) begin
      push_text("+IPD,");
      if ($urandom_range(0, 5) == 0) begin
        push_text(open_length_text());
        push_byte(ChColon, 1'b0);
        while (stream.size() != 0) push_byte(stream.pop_front(), 1'b0);
      end else begin
        take    = $urandom_range(1, stream.size());
        claimed = take;
        // now and then claim more than is sent, so the next marker is eaten
        if ($urandom_range(0, 7) == 0) claimed = take + $urandom_range(1, 4);
        push_text(length_text(claimed));
        push_byte(ChColon, 1'b0);
        repeat (take) push_byte(stream.pop_front(), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      push_byte(ChCr, 1'b0);
      push_byte(ChLf, 1'b0);
      push_text("CLOSED");
    end
    mark_end();
  endtask

  // Noise: random bytes, broken markers, and sometimes a marker with no colon.
  task automatic push_noise();
    int k;
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) push_byte(MarkText[i], 1'b0);
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if ($urandom_range(0, 1) == 0) begin
      push_text("+IPD,");
      push_text(length_text($urandom_range(0, 99)));
    end
    mark_end();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int       gap_left;
  int       burst_left;
  rx_item_t nxt;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) stall_cycles++;
      if (in_valid_i && in_ready_o) begin
        deframe_byte(rx_byte_i, end_of_response_i);
        bytes_sent++;
      end
      // hold the offered byte until it is taken; otherwise pick the next move
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          nxt = rx_pending.pop_front();
          in_valid_i        <= 1'b1;
          rx_byte_i         <= nxt.rx_byte;
          end_of_response_i <= nxt.eor;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) :
                                                       $urandom_range(0, 20);
            gap_left   = $urandom_range(1, 8);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer and drive the stall pattern
  // ---------------------------------------------------------------------------
  logic stall_hold = 1'b0;
  int   ready_mode;
  int   mode_left;
  int   beat;
  logic take_now;
  res_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (body_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual byte %02h data %0b last %0b",
                   $time, body_byte_o, has_data_o, body_last_o);
        end else begin
          want = body_expect.pop_front();
          if (body_byte_o !== want.body_byte) begin
            mismatches++;
            $display("%0t: body_byte expected %02h actual %02h", $time, want.body_byte,
                     body_byte_o);
          end
          if (has_data_o !== want.has_data) begin
            mismatches++;
            $display("%0t: has_data expected %0b actual %0b", $time, want.has_data,
                     has_data_o);
          end
          if (body_last_o !== want.body_last) begin
            mismatches++;
            $display("%0t: body_last expected %0b actual %0b", $time, want.body_last,
                     body_last_o);
          end
        end
      end
      // switch between always ready, coin flips, a sparse one-in-four beat and mostly ready
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      beat++;
      case (ready_mode)
        0:       take_now = 1'b1;
        1:       take_now = 1'($urandom_range(0, 1));
        2:       take_now = (beat % 4) == 0;
        default: take_now = $urandom_range(0, 7) != 0;
      endcase
      out_ready_i <= take_now && !stall_hold;
    end
  end

  // Hold off the receiver for a long stretch mid-run so the block backs up.
  initial begin
    wait (bytes_sent >= 700);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, reset, drain, report
  // ---------------------------------------------------------------------------
  initial begin
    reset_tracker();

    // end flag with nothing framed: a lone result with no data
    push_byte(8'h00, 1'b1);
    // counted frame whose last body byte is zero and ends the response
    push_text("+IPD,6:");
    push_blank_line();
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    // length past the counter's top, frame cut short by the end flag
    push_text("+IPD,99999:");
    push_byte(8'h80, 1'b1);

    while (rx_pending.size() < NumItems) begin
      if ($urandom_range(0, 4) == 0) push_noise();
      else push_response();
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (rx_pending.size() != 0 || in_valid_i);
    while (body_expect.size() != 0) @(posedge clk_i);
    // allow for any result still in the two-stage pipe
    repeat (16) @(posedge clk_i);

    $display("Drove %0d bytes in %0d responses; checked %0d results, %0d carrying body bytes.",
             bytes_sent, responses_seen, results_seen, body_bytes);
    $display("Input was stalled on %0d cycles; %0d field mismatches.", stall_cycles,
             mismatches);
    if (mismatches == 0) begin
      $display("[ipd_deframer_http_body_extractor] OK");
    end else begin
      $display("[ipd_deframer_http_body_extractor] ERROR");
    end
    $finish;
  end

endmodule

// ----- ipd_deframer_http_body_extractor.f -----
rtl/core/ipdbx_pkg.sv
rtl/core/ipdbx_parser.sv
rtl/core/ipdbx_skid.sv
rtl/core/ipd_deframer_http_body_extractor.sv
bench/tb.sv
